[hdl/dmc_pkg.sv]
`default_nettype none

package dmc_pkg;

	localparam int WORD_W        = 32;
	localparam int ADDR_W        = 32;
	localparam int OFFSET_W      = 4;
	localparam int TAG_W         = ADDR_W - OFFSET_W;
	localparam int LINE_WORDS    = 4;
	localparam int NUM_LINES_DEF = 512;

	// index reduction for line counts that are not a power of two
	localparam int MOD_BITS  = 4;
	localparam int MOD_STEPS = TAG_W / MOD_BITS;

	typedef enum logic [1:0] {
		KIND_PROBE = 2'd0,
		KIND_FILL  = 2'd1,
		KIND_WB    = 2'd2
	} kind_t;

	typedef enum logic [2:0] {
		ST_CLEAR,
		ST_IDLE,
		ST_MOD,
		ST_LOOK,
		ST_RESP,
		ST_WB
	} state_t;

	function automatic logic [WORD_W-1:0] swap32(input logic [WORD_W-1:0] w);
		return {w[7:0], w[15:8], w[23:16], w[31:24]};
	endfunction

endpackage

`default_nettype wire

[hdl/direct_mapped_data_cache.sv]
`default_nettype none

// channel   direction  handshake          payload
// input     in         start / busy       command, phys_addr, fill_word0..fill_word3
// result    out        strobe (1 cycle)   result_kind, hit, line_word0..line_word3,
//                                         writeback_addr, writeback_word, last
//
// an item is taken at a clock edge with start high and busy low
// power-of-two line count: a probe or a fill without eviction passes through the
//   memory read cycle and the response cycle; a fill that evicts gives its
//   four writeback words on consecutive cycles, one result per cycle on the result port
// other line counts first run the iterative index reduction, then a separate read
// after reset a clearing pass writes every line invalid, with busy high
// results are registered and shown for one cycle; the receiver cannot stall them

module direct_mapped_data_cache #(
	parameter int NUM_LINES = dmc_pkg::NUM_LINES_DEF
) (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         start,
	output      logic                         busy,
	input  wire logic                         command,
	input  wire logic [dmc_pkg::ADDR_W-1:0]   phys_addr,
	input  wire logic [dmc_pkg::WORD_W-1:0]   fill_word0,
	input  wire logic [dmc_pkg::WORD_W-1:0]   fill_word1,
	input  wire logic [dmc_pkg::WORD_W-1:0]   fill_word2,
	input  wire logic [dmc_pkg::WORD_W-1:0]   fill_word3,
	output      logic                         strobe,
	output      dmc_pkg::kind_t               result_kind,
	output      logic                         hit,
	output      logic [dmc_pkg::WORD_W-1:0]   line_word0,
	output      logic [dmc_pkg::WORD_W-1:0]   line_word1,
	output      logic [dmc_pkg::WORD_W-1:0]   line_word2,
	output      logic [dmc_pkg::WORD_W-1:0]   line_word3,
	output      logic [dmc_pkg::ADDR_W-1:0]   writeback_addr,
	output      logic [dmc_pkg::WORD_W-1:0]   writeback_word,
	output      logic                         last
);
	import dmc_pkg::*;

	localparam int IDX_W   = (NUM_LINES > 1) ? $clog2(NUM_LINES) : 1;
	localparam bit IS_POW2 = (NUM_LINES & (NUM_LINES - 1)) == 0;
	localparam int CNT_W   = $clog2(MOD_STEPS);

	// one memory entry: valid bit kept in the array, so reset needs a clearing pass
	typedef struct packed {
		logic                                valid;
		logic [TAG_W-1:0]                    tag;
		logic [LINE_WORDS-1:0][WORD_W-1:0]   data;
	} entry_t;

	entry_t mem [NUM_LINES];

	state_t state_q, state_d;

	// item payload, captured at accept
	logic                               cmd_q;
	logic [TAG_W-1:0]                   tag_q;
	logic [LINE_WORDS-1:0][WORD_W-1:0]  fill_q;      // already in stored byte order
	logic [IDX_W-1:0]                   idx_q;       // line index, or partial remainder
	logic [TAG_W-1:0]                   mod_sh_q;    // tag bits still to fold in
	logic [CNT_W-1:0]                   mod_cnt_q;
	logic [IDX_W-1:0]                   clr_q;       // clearing pass pointer
	logic [1:0]                         k_q;         // writeback word number
	entry_t                             rd_q;        // registered read data

	logic             accept;
	logic [IDX_W-1:0] in_idx;
	logic [IDX_W-1:0] rem_d;
	logic             rd_en;
	logic [IDX_W-1:0] rd_addr;
	logic             mem_we;
	logic [IDX_W-1:0] mem_waddr;
	entry_t           mem_wdata;
	logic [1:0]       wb_k;
	logic             hit_now;

	// next result
	logic                               out_load;
	kind_t                              kind_d;
	logic                               hit_d;
	logic [LINE_WORDS-1:0][WORD_W-1:0]  lw_d;
	logic [ADDR_W-1:0]                  wb_addr_d;
	logic [WORD_W-1:0]                  wb_word_d;
	logic                               last_d;

	assign busy    = (state_q != ST_IDLE);
	assign accept  = start && (state_q == ST_IDLE);
	assign in_idx  = phys_addr[OFFSET_W +: IDX_W];
	assign wb_k    = (state_q == ST_WB) ? k_q : 2'd0;
	assign hit_now = rd_q.valid && (rd_q.tag == tag_q);

	// remainder of the tag by NUM_LINES, four tag bits per cycle, msb first
	always_comb begin
		logic [IDX_W:0] r;
		r = {1'b0, idx_q};
		for (int i = 0; i < MOD_BITS; i++) begin
			r = {r[IDX_W-1:0], mod_sh_q[TAG_W-1-i]};
			if (r >= (IDX_W+1)'(NUM_LINES)) begin
				r = r - (IDX_W+1)'(NUM_LINES);
			end
		end
		rem_d = r[IDX_W-1:0];
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_CLEAR;
		end else begin
			state_q <= state_d;
		end
	end

	// next state, memory control and next result
	always_comb begin
		state_d   = state_q;
		rd_en     = 1'b0;
		rd_addr   = idx_q;
		mem_we    = 1'b0;
		mem_waddr = idx_q;
		mem_wdata = '0;
		out_load  = 1'b0;
		kind_d    = KIND_PROBE;
		hit_d     = 1'b0;
		lw_d      = '0;
		wb_addr_d = '0;
		wb_word_d = '0;
		last_d    = 1'b0;

		unique case (state_q)
			ST_CLEAR: begin
				mem_we    = 1'b1;
				mem_waddr = clr_q;
				if (clr_q == IDX_W'(NUM_LINES - 1)) begin
					state_d = ST_IDLE;
				end
			end
			ST_IDLE: begin
				// power-of-two size: index is a plain bit field, read right away
				rd_addr = in_idx;
				if (start) begin
					if (IS_POW2) begin
						rd_en   = 1'b1;
						state_d = ST_RESP;
					end else begin
						state_d = ST_MOD;
					end
				end
			end
			ST_MOD: begin
				if (mod_cnt_q == CNT_W'(MOD_STEPS - 1)) begin
					state_d = ST_LOOK;
				end
			end
			ST_LOOK: begin
				rd_en   = 1'b1;
				state_d = ST_RESP;
			end
			ST_RESP: begin
				out_load = 1'b1;
				if (!cmd_q) begin
					// probe answer, line words only on a hit
					kind_d  = KIND_PROBE;
					hit_d   = hit_now;
					lw_d    = hit_now ? rd_q.data : '0;
					last_d  = 1'b1;
					state_d = ST_IDLE;
				end else begin
					// fill always installs the new line; victim stays in rd_q
					mem_we          = 1'b1;
					mem_wdata.valid = 1'b1;
					mem_wdata.tag   = tag_q;
					mem_wdata.data  = fill_q;
					if (rd_q.valid) begin
						kind_d    = KIND_WB;
						wb_addr_d = {rd_q.tag, wb_k, 2'b00};
						wb_word_d = swap32(rd_q.data[wb_k]);
						state_d   = ST_WB;
					end else begin
						kind_d  = KIND_FILL;
						last_d  = 1'b1;
						state_d = ST_IDLE;
					end
				end
			end
			ST_WB: begin
				out_load  = 1'b1;
				kind_d    = KIND_WB;
				wb_addr_d = {rd_q.tag, wb_k, 2'b00};
				wb_word_d = swap32(rd_q.data[wb_k]);
				last_d    = (k_q == 2'd3);
				if (k_q == 2'd3) begin
					state_d = ST_IDLE;
				end
			end
			default: begin
				state_d = ST_IDLE;
			end
		endcase
	end

	// control counters and result strobe
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			clr_q  <= '0;
			strobe <= 1'b0;
		end else begin
			strobe <= out_load;
			if (state_q == ST_CLEAR) begin
				clr_q <= clr_q + IDX_W'(1);
			end
		end
	end

	// item payload and index reduction
	always_ff @(posedge clk) begin
		if (accept) begin
			cmd_q     <= command;
			tag_q     <= phys_addr[ADDR_W-1:OFFSET_W];
			fill_q[0] <= swap32(fill_word0);
			fill_q[1] <= swap32(fill_word1);
			fill_q[2] <= swap32(fill_word2);
			fill_q[3] <= swap32(fill_word3);
			mod_sh_q  <= phys_addr[ADDR_W-1:OFFSET_W];
			mod_cnt_q <= '0;
			idx_q     <= IS_POW2 ? in_idx : '0;
		end else if (state_q == ST_MOD) begin
			idx_q     <= rem_d;
			mod_sh_q  <= mod_sh_q << MOD_BITS;
			mod_cnt_q <= mod_cnt_q + CNT_W'(1);
		end
		if (state_q == ST_RESP) begin
			k_q <= 2'd1;
		end else if (state_q == ST_WB) begin
			k_q <= k_q + 2'd1;
		end
	end

	// tag/data memory: one write port, one registered read port
	always_ff @(posedge clk) begin
		if (mem_we) begin
			mem[mem_waddr] <= mem_wdata;
		end
		if (rd_en) begin
			rd_q <= mem[rd_addr];
		end
	end

	// result registers
	always_ff @(posedge clk) begin
		if (out_load) begin
			result_kind    <= kind_d;
			hit            <= hit_d;
			line_word0     <= lw_d[0];
			line_word1     <= lw_d[1];
			line_word2     <= lw_d[2];
			line_word3     <= lw_d[3];
			writeback_addr <= wb_addr_d;
			writeback_word <= wb_word_d;
			last           <= last_d;
		end
	end

endmodule

`default_nettype wire

[hdl/dmc_checker.sv]
`default_nettype none

module dmc_checker (
	input wire logic                        clk,
	input wire logic                        arst_n,
	input wire logic                        start,
	input wire logic                        busy,
	input wire logic                        strobe,
	input wire dmc_pkg::kind_t              result_kind,
	input wire logic [dmc_pkg::ADDR_W-1:0]  writeback_addr,
	input wire logic                        last
);
	import dmc_pkg::*;

	// a taken item keeps the block busy on the next cycle
	a_accept_busy: assert property (@(posedge clk) disable iff (!arst_n)
		start && !busy |=> busy)
		else $error("busy low right after an item was taken");

	// probe answers and plain fill acks are single results
	a_single_last: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && (result_kind == KIND_PROBE || result_kind == KIND_FILL) |-> last)
		else $error("single result without last");

	// writeback words follow back to back
	a_wb_burst: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && !last |=> strobe && result_kind == KIND_WB)
		else $error("writeback burst broken");

	// writeback addresses step one word at a time
	a_wb_addr: assert property (@(posedge clk) disable iff (!arst_n)
		strobe && result_kind == KIND_WB && !last
			|=> writeback_addr == $past(writeback_addr) + 32'd4)
		else $error("writeback address not sequential");

endmodule

bind direct_mapped_data_cache dmc_checker u_dmc_checker (
	.clk            (clk),
	.arst_n         (arst_n),
	.start          (start),
	.busy           (busy),
	.strobe         (strobe),
	.result_kind    (result_kind),
	.writeback_addr (writeback_addr),
	.last           (last)
);

`default_nettype wire
